>>> design/edf_pkg.sv
// shared types and constants for the edf periodic task scheduler
package edf_pkg;

  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = 3;
  localparam int TIME_W    = 32;
  localparam int WORK_W    = 16;
  localparam int CNT_W     = 4;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CNT_W-1:0] TASK_COUNT_RST = CNT_W'(1);

  localparam logic REG_TASK_COUNT = 1'b0;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] deadline;
    logic [SLOT_W-1:0] slot;
  } cand_t;

  typedef struct packed {
    logic              load;
    logic              rel;
    logic              dec;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
  } cell_ctl_t;

endpackage

>>> design/edf_cell.sv
// one task slot: task state plus one stage of the deadline compare chain
module edf_cell import edf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [SLOT_W-1:0] slot_idx_i,
  input  logic [CNT_W-1:0]  task_count_i,
  input  logic [WORK_W-1:0] exec_time_i,
  input  logic [WORK_W-1:0] release_period_i,
  input  logic [WORK_W-1:0] relative_deadline_i,
  input  cand_t             cand_i,
  output cand_t             cand_o
);

  logic [WORK_W-1:0] exec_q, exec_d;
  logic [WORK_W-1:0] period_q, period_d;
  logic [WORK_W-1:0] offset_q, offset_d;
  logic [WORK_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] next_rel_q, next_rel_d;
  logic [TIME_W-1:0] dl_q, dl_d;
  cand_t             cand_q, cand_d;

  logic active;
  logic hit;
  logic eligible;

  assign active   = {1'b0, slot_idx_i} < task_count_i;
  assign hit      = ctl_i.slot == slot_idx_i;
  assign eligible = active && (rem_q != '0);

  always_comb begin
    exec_d     = exec_q;
    period_d   = period_q;
    offset_d   = offset_q;
    rem_d      = rem_q;
    next_rel_d = next_rel_q;
    dl_d       = dl_q;
    if (ctl_i.load && hit) begin
      exec_d     = exec_time_i;
      period_d   = release_period_i;
      offset_d   = relative_deadline_i;
      rem_d      = '0;
      next_rel_d = '0;
      dl_d       = '0;
    end else if (ctl_i.rel && active && (next_rel_q == ctl_i.now)) begin
      rem_d      = exec_q;
      dl_d       = ctl_i.now + TIME_W'(offset_q);
      next_rel_d = next_rel_q + TIME_W'(period_q);
    end else if (ctl_i.dec && hit) begin
      rem_d = rem_q - WORK_W'(1);
    end
  end

  // keep incoming winner unless this slot is eligible and strictly earlier
  always_comb begin
    cand_d = cand_i;
    if (eligible && (!cand_i.found || (dl_q < cand_i.deadline))) begin
      cand_d.found    = 1'b1;
      cand_d.deadline = dl_q;
      cand_d.slot     = slot_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q     <= '0;
      period_q   <= '0;
      offset_q   <= '0;
      rem_q      <= '0;
      next_rel_q <= '0;
      dl_q       <= '0;
      cand_q     <= '0;
    end else begin
      exec_q     <= exec_d;
      period_q   <= period_d;
      offset_q   <= offset_d;
      rem_q      <= rem_d;
      next_rel_q <= next_rel_d;
      dl_q       <= dl_d;
      cand_q     <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

>>> design/edf_ctrl.sv
// tick sequencer, time counter and result register
module edf_ctrl import edf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [SLOT_W-1:0] task_slot_i,
  input  cand_t             cand_i,
  output cell_ctl_t         ctl_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              idle_o,
  output logic [SLOT_W-1:0] running_slot_o,
  output logic [TIME_W-1:0] tick_time_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic              out_valid_q, out_valid_d;
  logic              idle_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] tick_q;

  logic accept;
  logic scan_end;
  logic emit;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign scan_end = cnt_q == SLOT_W'(MAX_TASKS - 1);
  assign emit     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && (kind_i == KIND_TICK)) state_d = ST_SCAN;
      ST_SCAN: if (scan_end) state_d = ST_DONE;
      ST_DONE: if (emit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    ctl_o.load  = accept && (kind_i == KIND_LOAD);
    ctl_o.rel   = accept && (kind_i == KIND_TICK);
    ctl_o.dec   = emit && cand_i.found;
    ctl_o.slot  = (state_q == ST_DONE) ? cand_i.slot : task_slot_i;
    ctl_o.now   = time_q;
    cnt_d       = (state_q == ST_SCAN) ? cnt_q + SLOT_W'(1) : '0;
    time_d      = emit ? time_q + TIME_W'(1) : time_q;
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      idle_q <= !cand_i.found;
      slot_q <= cand_i.found ? cand_i.slot : '0;
      tick_q <= time_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign idle_o         = idle_q;
  assign running_slot_o = slot_q;
  assign tick_time_o    = tick_q;

endmodule

>>> design/edf_periodic_task_scheduler_core.sv
// top level of the edf periodic task scheduler: register port, cell chain, sequencer
// a load word is written into its slot as it is accepted and yields no result
// a tick word releases due tasks, then runs MAX_TASKS stages of the deadline compare chain,
// then commits the winner and registers the result once the output side is free
// the input is stalled while a tick is in flight; the result register frees the output side
// reset is asynchronous, active low, and clears all task state, time, and sets task_count to 1
module edf_periodic_task_scheduler_core import edf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [SLOT_W-1:0] task_slot_i,
  input  logic [WORK_W-1:0] exec_time_i,
  input  logic [WORK_W-1:0] release_period_i,
  input  logic [WORK_W-1:0] relative_deadline_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              idle_o,
  output logic [SLOT_W-1:0] running_slot_o,
  output logic [TIME_W-1:0] tick_time_o
);

  logic [CNT_W-1:0] task_count_q, task_count_d;
  logic             reg_sel;
  cell_ctl_t        ctl;
  cand_t            chain [MAX_TASKS+1];

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_TASK_COUNT;
  assign prdata  = reg_sel ? DATA_W'(task_count_q) : '0;

  always_comb begin
    task_count_d = task_count_q;
    if (psel && penable && pwrite && reg_sel) begin
      task_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TASK_COUNT_RST;
    end else begin
      task_count_q <= task_count_d;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    edf_cell u_cell (
      .clk_i               (clk_i),
      .rst_ni              (rst_ni),
      .ctl_i               (ctl),
      .slot_idx_i          (SLOT_W'(i)),
      .task_count_i        (task_count_q),
      .exec_time_i         (exec_time_i),
      .release_period_i    (release_period_i),
      .relative_deadline_i (relative_deadline_i),
      .cand_i              (chain[i]),
      .cand_o              (chain[i+1])
    );
  end

  edf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .task_slot_i    (task_slot_i),
    .cand_i         (chain[MAX_TASKS]),
    .ctl_o          (ctl),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .idle_o         (idle_o),
    .running_slot_o (running_slot_o),
    .tick_time_o    (tick_time_o)
  );

endmodule

>>> design/edf_checker.sv
// port-level checker for the scheduler core and its bind
module edf_checker import edf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              kind_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              idle_o,
  input logic [SLOT_W-1:0] running_slot_o,
  input logic [TIME_W-1:0] tick_time_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tick_time_o))
    else $error("stalled result word changed");

  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> running_slot_o == '0)
    else $error("idle result with nonzero slot");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_TICK) |=> in_stall_o)
    else $error("tick word did not occupy the block");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_LOAD) |=> !in_stall_o)
    else $error("load word left the block busy");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared without a tick in flight");

endmodule

bind edf_periodic_task_scheduler_core edf_checker u_edf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .idle_o         (idle_o),
  .running_slot_o (running_slot_o),
  .tick_time_o    (tick_time_o)
);
